[design/rbe_pkg.sv]
// ----------------------------------------------------------------------------
// rbe_pkg: shared types and constants of the ray box exit unit
// Field widths, divider sizing and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package rbe_pkg;

  localparam int unsigned POS_W    = 24;  // positions, 8 fraction bits
  localparam int unsigned DIR_W    = 16;  // direction magnitude, Q1.15
  localparam int unsigned DIR_FRAC = 15;
  // |wall - origin| < 2^24, shifted by DIR_FRAC: quotient below 2^39
  localparam int unsigned QUO_W    = POS_W + DIR_FRAC;
  localparam int unsigned ADDR_W   = 5;

  typedef enum logic [2:0] {
    REG_X_MIN = 3'd0,
    REG_X_MAX = 3'd1,
    REG_Y_MIN = 3'd2,
    REG_Y_MAX = 3'd3,
    REG_Z_MIN = 3'd4,
    REG_Z_MAX = 3'd5
  } reg_idx_e;

  localparam logic signed [POS_W-1:0] BOX_MIN_RST = -24'sd131072;
  localparam logic signed [POS_W-1:0] BOX_MAX_RST = 24'sd131072;

  // per-ray data that rides alongside the dividers
  typedef struct packed {
    logic [2:0][POS_W-1:0] origin;
    logic [2:0][DIR_W-1:0] dmag;
    logic [2:0]            dneg;
    logic [5:0]            lane_ok;
    logic                  in_box;
  } side_t;

endpackage

`default_nettype wire

[design/rbe_div.sv]
// ----------------------------------------------------------------------------
// rbe_div: pipelined restoring divider
// Computes floor((num << DIR_FRAC) / den), one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rbe_div (
  input  wire                        clk_i,
  input  wire                        en_i,
  input  wire  [rbe_pkg::POS_W-1:0]  num_i,
  input  wire  [rbe_pkg::DIR_W-1:0]  den_i,
  output logic [rbe_pkg::QUO_W-1:0]  quo_o
);
  import rbe_pkg::*;

  // nq holds remaining dividend bits, quotient bits shift in from the right
  logic [QUO_W-1:0] nq_q [QUO_W];
  logic [DIR_W-1:0] r_q  [QUO_W];
  logic [DIR_W-1:0] d_q  [QUO_W];
  logic [QUO_W-1:0] nq_d [QUO_W];
  logic [DIR_W-1:0] r_d  [QUO_W];

  always_comb begin
    logic [QUO_W-1:0] nq_in;
    logic [DIR_W-1:0] r_in;
    logic [DIR_W-1:0] d_in;
    logic [DIR_W:0]   rs;
    logic             ge;
    for (int k = 0; k < QUO_W; k++) begin
      if (k == 0) begin
        nq_in = {num_i, {DIR_FRAC{1'b0}}};
        r_in  = '0;
        d_in  = den_i;
      end else begin
        nq_in = nq_q[k-1];
        r_in  = r_q[k-1];
        d_in  = d_q[k-1];
      end
      rs      = {r_in, nq_in[QUO_W-1]};
      ge      = (rs >= {1'b0, d_in});
      r_d[k]  = ge ? DIR_W'(rs - {1'b0, d_in}) : rs[DIR_W-1:0];
      nq_d[k] = {nq_in[QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0] <= den_i;
      for (int k = 0; k < QUO_W; k++) begin
        nq_q[k] <= nq_d[k];
        r_q[k]  <= r_d[k];
      end
      for (int k = 1; k < QUO_W; k++) d_q[k] <= d_q[k-1];
    end
  end

  assign quo_o = nq_q[QUO_W-1];

endmodule

`default_nettype wire

[design/ray_box_exit_unit.sv]
// ----------------------------------------------------------------------------
// ray_box_exit_unit: exit point of a ray from an axis-aligned box
// Slab test against six configured walls, nearest wall ahead, exit point.
// ----------------------------------------------------------------------------
// Accepts one ray request per clock and returns one result per ray, in order,
// through 1 setup stage, 39 divider stages, 2 min stages, and the multiply,
// sum and exit/saturate stages. The latency is set by the six
// bit-serial-in-space dividers, one quotient bit per stage. The whole pipeline
// advances together: when the output is held, input ready drops in the same
// cycle and nothing is lost. Positions are 24-bit two's complement with 8
// fraction bits; path length uses the same scale, so the math does not depend
// on the fraction count. Box walls are written over APB at 4*index and read
// back sign-extended; change them only while no ray is in flight.
`default_nettype none

module ray_box_exit_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  // origin_x, origin_y, origin_z (24b each), dir_x, dir_y, dir_z (16b each)
  input  wire [119:0] s_axis_tdata_i,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // exit_x, exit_y, exit_z, path_length (24b each)
  output logic [95:0] m_axis_tdata_o,
  // exit_found, origin_inside
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [rbe_pkg::ADDR_W-1:0] paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rbe_pkg::*;

  localparam int unsigned DIV_LAT = QUO_W;

  // ---------------- configuration ----------------
  logic signed [POS_W-1:0] box_q [6];
  logic [2:0]              widx;

  assign pready = 1'b1;
  assign widx   = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q[REG_X_MIN] <= BOX_MIN_RST;
      box_q[REG_X_MAX] <= BOX_MAX_RST;
      box_q[REG_Y_MIN] <= BOX_MIN_RST;
      box_q[REG_Y_MAX] <= BOX_MAX_RST;
      box_q[REG_Z_MIN] <= BOX_MIN_RST;
      box_q[REG_Z_MAX] <= BOX_MAX_RST;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_X_MIN, REG_X_MAX, REG_Y_MIN,
        REG_Y_MAX, REG_Z_MIN, REG_Z_MAX: box_q[widx] <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_X_MIN, REG_X_MAX, REG_Y_MIN,
      REG_Y_MAX, REG_Z_MIN, REG_Z_MAX: prdata = 32'(box_q[widx]);
      default: prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // single enable: everything moves when the output slot is free or taken
  logic adv;
  logic out_v_q;
  assign adv             = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // ---------------- stage 0: wall distances ----------------
  logic signed [POS_W-1:0] o_in [3];
  logic signed [DIR_W-1:0] d_in [3];
  side_t                   side_d;
  logic [POS_W-1:0]        mag_d [6];

  always_comb begin
    logic signed [POS_W:0] diff;
    side_d = '0;
    side_d.in_box = 1'b1;
    for (int a = 0; a < 3; a++) begin
      o_in[a] = s_axis_tdata_i[a*POS_W +: POS_W];
      d_in[a] = s_axis_tdata_i[3*POS_W + a*DIR_W +: DIR_W];
      side_d.origin[a] = o_in[a];
      side_d.dneg[a]   = d_in[a][DIR_W-1];
      side_d.dmag[a]   = d_in[a][DIR_W-1] ? DIR_W'(-d_in[a]) : d_in[a];
      if (o_in[a] < box_q[2*a] || o_in[a] > box_q[2*a+1])
        side_d.in_box = 1'b0;
      for (int s = 0; s < 2; s++) begin
        diff = (POS_W+1)'(box_q[2*a+s]) - (POS_W+1)'(o_in[a]);
        // wall counts only if it lies in the direction of travel
        side_d.lane_ok[2*a+s] = (diff != 0) && (d_in[a] != 0) &&
                                (diff[POS_W] == d_in[a][DIR_W-1]);
        mag_d[2*a+s] = diff[POS_W] ? POS_W'(-diff) : diff[POS_W-1:0];
      end
    end
  end

  logic             v0_q;
  side_t            side0_q;
  logic [POS_W-1:0] mag0_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (adv) v0_q <= s_axis_tvalid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side0_q <= side_d;
      for (int l = 0; l < 6; l++) mag0_q[l] <= mag_d[l];
    end
  end

  // ---------------- dividers: t = (|diff| << 15) / |dir| ----------------
  logic [QUO_W-1:0] quo [6];

  for (genvar l = 0; l < 6; l++) begin : g_div
    rbe_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (mag0_q[l]),
      .den_i (side0_q.dmag[l/2]),
      .quo_o (quo[l])
    );
  end

  logic  dv_q   [DIV_LAT];
  side_t dside_q[DIV_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_LAT; k++) dv_q[k] <= 1'b0;
    end else if (adv) begin
      dv_q[0] <= v0_q;
      for (int k = 1; k < DIV_LAT; k++) dv_q[k] <= dv_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dside_q[0] <= side0_q;
      for (int k = 1; k < DIV_LAT; k++) dside_q[k] <= dside_q[k-1];
    end
  end

  side_t dside;
  assign dside = dside_q[DIV_LAT-1];

  // ---------------- min stage 1: pairs ----------------
  logic             m1v_q;
  side_t            m1side_q;
  logic [2:0]       m1ok_q;
  logic [QUO_W-1:0] m1t_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m1v_q <= 1'b0;
    else if (adv) m1v_q <= dv_q[DIV_LAT-1];
  end

  always_ff @(posedge clk_i) begin
    logic ca, cb;
    if (adv) begin
      m1side_q <= dside;
      for (int p = 0; p < 3; p++) begin
        // a wall at zero distance does not count as ahead
        ca = dside.lane_ok[2*p]   && (quo[2*p]   != '0);
        cb = dside.lane_ok[2*p+1] && (quo[2*p+1] != '0);
        m1ok_q[p] <= ca || cb;
        if (ca && (!cb || quo[2*p] <= quo[2*p+1])) m1t_q[p] <= quo[2*p];
        else m1t_q[p] <= quo[2*p+1];
      end
    end
  end

  // ---------------- min stage 2: best of three ----------------
  logic             m2v_q;
  side_t            m2side_q;
  logic             m2found_q;
  logic [QUO_W-1:0] m2t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m2v_q <= 1'b0;
    else if (adv) m2v_q <= m1v_q;
  end

  always_ff @(posedge clk_i) begin
    logic             f;
    logic [QUO_W-1:0] t;
    if (adv) begin
      f = m1ok_q[0];
      t = m1t_q[0];
      for (int p = 1; p < 3; p++) begin
        if (m1ok_q[p] && (!f || m1t_q[p] < t)) begin
          t = m1t_q[p];
          f = 1'b1;
        end
      end
      m2side_q  <= m1side_q;
      m2found_q <= f;
      m2t_q     <= t;
    end
  end

  // ---------------- multiply: t * |dir|, split in two halves ----------------
  localparam int unsigned LO_W = 20;
  localparam int unsigned HI_W = QUO_W - LO_W;

  logic                    pv_q;
  side_t                   pside_q;
  logic                    pfound_q;
  logic [POS_W-1:0]        plen_q;
  logic [HI_W+DIR_W-1:0]   phi_q [3];
  logic [LO_W+DIR_W-1:0]   plo_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv_q <= 1'b0;
    else if (adv) pv_q <= m2v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pside_q  <= m2side_q;
      pfound_q <= m2found_q;
      if (!m2found_q) plen_q <= '0;
      else if (m2t_q[QUO_W-1:POS_W] != '0) plen_q <= '1;
      else plen_q <= m2t_q[POS_W-1:0];
      for (int a = 0; a < 3; a++) begin
        phi_q[a] <= (HI_W+DIR_W)'(m2t_q[QUO_W-1:LO_W]) *
                    (HI_W+DIR_W)'(m2side_q.dmag[a]);
        plo_q[a] <= (LO_W+DIR_W)'(m2t_q[LO_W-1:0]) * (LO_W+DIR_W)'(m2side_q.dmag[a]);
      end
    end
  end

  // ---------------- sum and round: offset = (t*|dir| + 2^14) >> 15 ----------------
  localparam int unsigned SUM_W = QUO_W + DIR_W + 1;
  localparam int unsigned OFF_W = SUM_W - DIR_FRAC;

  logic             av_q;
  side_t            aside_q;
  logic             afound_q;
  logic [POS_W-1:0] alen_q;
  logic [OFF_W-1:0] aoff_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) av_q <= 1'b0;
    else if (adv) av_q <= pv_q;
  end

  always_ff @(posedge clk_i) begin
    logic [SUM_W-1:0] sum;
    if (adv) begin
      aside_q  <= pside_q;
      afound_q <= pfound_q;
      alen_q   <= plen_q;
      for (int a = 0; a < 3; a++) begin
        sum = (SUM_W'(phi_q[a]) << LO_W) + SUM_W'(plo_q[a]) +
              (SUM_W'(1) << (DIR_FRAC - 1));
        aoff_q[a] <= sum[SUM_W-1:DIR_FRAC];
      end
    end
  end

  // ---------------- exit point and output register ----------------
  localparam int unsigned E_W = OFF_W + 2;
  localparam logic signed [E_W-1:0] E_MAX = E_W'(2**(POS_W-1) - 1);
  localparam logic signed [E_W-1:0] E_MIN = -E_W'(2**(POS_W-1));

  logic [95:0] tdata_q;
  logic [1:0]  tuser_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (adv) out_v_q <= av_q;
  end

  always_ff @(posedge clk_i) begin
    logic signed [E_W-1:0] e;
    logic signed [E_W-1:0] off;
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        e   = E_W'($signed(aside_q.origin[a]));
        off = $signed({2'b00, aoff_q[a]});
        if (afound_q && aside_q.dmag[a] != '0) begin
          e = aside_q.dneg[a] ? e - off : e + off;
        end
        if (e > E_MAX) tdata_q[a*POS_W +: POS_W] <= E_MAX[POS_W-1:0];
        else if (e < E_MIN) tdata_q[a*POS_W +: POS_W] <= E_MIN[POS_W-1:0];
        else tdata_q[a*POS_W +: POS_W] <= e[POS_W-1:0];
      end
      tdata_q[3*POS_W +: POS_W] <= alen_q;
      tuser_q <= {aside_q.in_box, afound_q};
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tuser_o  = tuser_q;

`ifndef SYNTHESIS
  // a held result must block new requests
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted while output stalled");

  // an exit always lies at a positive distance
  a_found_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o[95:72] != '0))
    else $error("exit found with zero path length");

  // no exit means no length
  a_nofound_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tdata_o[95:72] == '0))
    else $error("path length without exit");
`endif

endmodule

`default_nettype wire

[verif/ray_box_exit_unit_tb.sv]
// ----------------------------------------------------------------------------
// ray_box_exit_unit_tb: self-checking bench for the ray box exit unit
// Streams rays with random gaps and output stalls, predicts each exit result
// from the configured box and compares every field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_box_exit_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rbe_pkg::*;

  localparam int LATENCY = 45;

  typedef struct packed {
    logic signed [23:0] ox, oy, oz;
    logic signed [15:0] dx, dy, dz;
  } ray_t;

  typedef struct packed {
    logic [23:0] ex, ey, ez, len;
    logic        found, in_box;
  } exit_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic [119:0] s_tdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]  pwdata = '0, prdata;
  logic         pready;

  ray_box_exit_unit uut (
    .clk_i, .rst_ni,
    .s_axis_tdata_i(s_tdata), .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial forever #6 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // testbench copy of the box walls, indexed by axis (reg_idx_e >> 1)
  logic signed [23:0] box_lo [3];
  logic signed [23:0] box_hi [3];

  ray_t  ray_q  [$];   // rays waiting to be driven
  exit_t exit_q [$];   // predicted exits, oldest first
  int    errors = 0;
  bit    feeding = 1'b1;

  function automatic void queue_ray(ray_t r);
    ray_q.insert(ray_q.size(), r);
  endfunction

  function automatic logic [23:0] sat24(longint v);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  function automatic exit_t predict_exit(ray_t r);
    exit_t   e;
    longint  o [3], d [3], dm, diff, t, best, off, pos;
    bit      found, in_box;
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
    found = 0; in_box = 1; best = 0;
    for (int a = 0; a < 3; a++)
      if (o[a] < box_lo[a] || o[a] > box_hi[a]) in_box = 0;
    for (int a = 0; a < 3; a++) begin
      if (d[a] == 0) continue;
      dm = d[a] < 0 ? -d[a] : d[a];
      for (int s = 0; s < 2; s++) begin
        diff = (s ? longint'(box_hi[a]) : longint'(box_lo[a])) - o[a];
        // wall on or behind the origin is skipped
        if (diff == 0 || ((diff < 0) != (d[a] < 0))) continue;
        t = ((diff < 0 ? -diff : diff) << 15) / dm;
        if (t >= 1 && (!found || t < best)) begin
          best = t;
          found = 1;
        end
      end
    end
    for (int a = 0; a < 3; a++) begin
      pos = o[a];
      if (found && d[a] != 0) begin
        dm = d[a] < 0 ? -d[a] : d[a];
        off = (best * dm + (1 << 14)) >>> 15;
        pos = d[a] < 0 ? pos - off : pos + off;
      end
      if (a == 0) e.ex = sat24(pos);
      else if (a == 1) e.ey = sat24(pos);
      else e.ez = sat24(pos);
    end
    e.len = !found ? 24'd0 : (best > 16777215 ? 24'hFFFFFF : best[23:0]);
    e.found = found;
    e.in_box = in_box;
    return e;
  endfunction

  // driver: one ray per handshake, random gap drawn per ray (0 = back to back)
  int   gap_cnt = 0;
  ray_t cur_ray;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_tvalid || s_tready) begin
        if (s_tvalid) exit_q.insert(exit_q.size(), predict_exit(cur_ray));
        if (gap_cnt > 0) begin
          gap_cnt  <= gap_cnt - 1;
          s_tvalid <= 1'b0;
        end else if (feeding && ray_q.size() > 0) begin
          cur_ray  = ray_q.pop_front();
          s_tdata  <= {cur_ray.dz, cur_ray.dy, cur_ray.dx,
                       cur_ray.oz, cur_ray.oy, cur_ray.ox};
          s_tvalid <= 1'b1;
          gap_cnt  <= $urandom_range(0, 11);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random stall per result, field-by-field compare
  int    stall_cnt = 0;
  int    stall_draw;
  exit_t want, got;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[23:0], m_tdata[47:24], m_tdata[71:48], m_tdata[95:72],
                m_tuser[0], m_tuser[1]};
        if (exit_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
          errors++;
        end else begin
          want = exit_q.pop_front();
          if (got.ex !== want.ex || got.ey !== want.ey || got.ez !== want.ez) begin
            $display("%0t: exit point expected %h %h %h actual %h %h %h", $realtime,
                     want.ex, want.ey, want.ez, got.ex, got.ey, got.ez);
            errors++;
          end
          if (got.len !== want.len) begin
            $display("%0t: path_length expected %h actual %h", $realtime,
                     want.len, got.len);
            errors++;
          end
          if (got.found !== want.found || got.in_box !== want.in_box) begin
            $display("%0t: found/inside expected %b%b actual %b%b", $realtime,
                     want.found, want.in_box, got.found, got.in_box);
            errors++;
          end
        end
        stall_draw = $urandom_range(0, 11);
        if (stall_draw > 0) begin
          m_tready  <= 1'b0;
          stall_cnt <= stall_draw - 1;
        end
      end else if (!m_tready) begin
        if (stall_cnt > 0) stall_cnt <= stall_cnt - 1;
        else m_tready <= 1'b1;
      end
    end
  end

  // APB write: setup then access; pready is tied high in the block
  task automatic write_wall(reg_idx_e idx, logic signed [23:0] v);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_W'(4 * int'(idx)); pwdata <= {{8{v[23]}}, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx[0]) box_hi[int'(idx) >> 1] = v;
    else box_lo[int'(idx) >> 1] = v;
  endtask

  task automatic set_box(logic signed [23:0] lo[3], logic signed [23:0] hi[3]);
    for (int a = 0; a < 3; a++) begin
      write_wall(reg_idx_e'(2 * a), lo[a]);
      write_wall(reg_idx_e'(2 * a + 1), hi[a]);
    end
  endtask

  // wait until every request queued so far has come back, plus pipeline drain
  task automatic drain();
    do @(negedge clk_i);
    while (ray_q.size() != 0 || s_tvalid || exit_q.size() != 0);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_dir();
    case ($urandom_range(0, 7))
      0: return 16'sd0;
      1: return 16'sh7FFF;
      2: return 16'sh8000;
      3: return 16'(int'($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [23:0] rand_pos(int a);
    case ($urandom_range(0, 9))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return box_lo[a];
      3: return box_hi[a];
      4: return 24'($urandom);
      default: return 24'(int'($urandom_range(0, 2 * 262144)) - 262144 +
                          (int'(box_lo[a]) + int'(box_hi[a])) / 2);
    endcase
  endfunction

  task automatic add_rays(int n);
    ray_t r;
    for (int i = 0; i < n; i++) begin
      r.ox = rand_pos(0); r.oy = rand_pos(1); r.oz = rand_pos(2);
      r.dx = rand_dir();  r.dy = rand_dir();  r.dz = rand_dir();
      queue_ray(r);
    end
  endtask

  initial begin
    logic signed [23:0] lo [3], hi [3];
    box_lo = '{BOX_MIN_RST, BOX_MIN_RST, BOX_MIN_RST};
    box_hi = '{BOX_MAX_RST, BOX_MAX_RST, BOX_MAX_RST};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset box, center, walls, extremes, zero direction
    queue_ray('{0, 0, 0, 16'sh7FFF, 0, 0});
    queue_ray('{0, 0, 0, 16'sh8000, 0, 0});
    queue_ray('{0, 0, 0, 0, 0, 0});
    queue_ray('{131072, 0, 0, 16'sh7FFF, 0, 0});      // on wall, leaving
    queue_ray('{131072, 0, 0, 16'sh8000, 0, 0});      // on wall, going in
    queue_ray('{-131072, -131072, -131072, 1, 1, 1}); // corner, tiny dir
    queue_ray('{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 16'sh8000, 16'sh8000,
                16'sh8000});
    queue_ray('{24'sh800000, 24'sh800000, 24'sh800000, 1, 1, 1});
    queue_ray('{24'sh800000, 0, 0, 16'sh7FFF, 0, 0});
    queue_ray('{131071, 0, 0, 1, 0, 0});               // next to wall, tiny dir
    queue_ray('{0, 0, 0, 18919, 18919, 18919});
    queue_ray('{0, 24'sh7FFFFF, 0, 16'sh8000, 16'shFFFF, 0});
    queue_ray('{1000, -2000, 300, 16'sh7FFF, 16'sh7FFF, 16'sh8000});
    queue_ray('{0, 0, 0, 16'shFFFF, 1, 16'sh8001});
    drain();

    // extreme box, then inverted box, then random boxes
    lo = '{24'sh800000, 24'sh800000, 24'sh800000};
    hi = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF};
    set_box(lo, hi);
    queue_ray('{0, 0, 0, 1, 16'shFFFF, 0});
    queue_ray('{24'sh7FFFFF, 24'sh800000, 0, 16'sh7FFF, 16'sh8000, 1});
    add_rays(130);
    drain();

    lo = '{1000, 5000, 24'sh7FFFFF};
    hi = '{-1000, -5000, 24'sh800000};
    set_box(lo, hi);
    add_rays(130);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      for (int a = 0; a < 3; a++) begin
        lo[a] = 24'(int'($urandom_range(0, 400000)) - 200000);
        hi[a] = lo[a] + 24'(int'($urandom_range(0, 300000)));
      end
      if (ph == 5) lo[0] = hi[0];   // zero-width slab
      set_box(lo, hi);
      add_rays(ph == 5 ? 60 : 100);
      drain();
    end

    feeding = 1'b0;
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
design/rbe_pkg.sv
design/rbe_div.sv
design/ray_box_exit_unit.sv
verif/ray_box_exit_unit_tb.sv
